/* sv/vcsg_pkg.sv */
// vcsg_pkg: payload types, register map and saturation helpers of the
// five-point stencil row generator. No dependencies.
`default_nettype none

package vcsg_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int COEF_WIDTH  = 48;
    localparam int WIDE_WIDTH  = COEF_WIDTH + 2;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = ADDR_W - 2;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_COND = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATIO_X_Y   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RATIO_Y_X   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_MODE  = 3'd5;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // entry slots of one point, emitted in ascending order
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_S = 0;
    localparam int SLOT_W = 1;
    localparam int SLOT_C = 2;
    localparam int SLOT_E = 3;
    localparam int SLOT_N = 4;
    localparam int SLOT_F = 5;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] point_col;
        logic [COORD_WIDTH-1:0] point_row;
    } t_in_item;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]       entry_col;
        logic [COORD_WIDTH-1:0]       entry_row;
        logic signed [COEF_WIDTH-1:0] coefficient;
        logic                         last_entry;
        logic                         out_of_grid;
    } t_out_item;

    localparam logic [WIDE_WIDTH-1:0] POS_MAX = WIDE_WIDTH'((64'd1 << (COEF_WIDTH - 1)) - 64'd1);
    localparam logic [COEF_WIDTH-1:0] NEG_MAG = COEF_WIDTH'(64'd1 << (COEF_WIDTH - 1));

    function automatic logic [COEF_WIDTH-1:0] sat_pos(input logic [WIDE_WIDTH-1:0] m);
        return (m > POS_MAX) ? COEF_WIDTH'(POS_MAX) : COEF_WIDTH'(m);
    endfunction

    function automatic logic [COEF_WIDTH-1:0] sat_neg(input logic [COEF_WIDTH-1:0] m);
        logic [COEF_WIDTH-1:0] mag;
        mag = (m > NEG_MAG) ? NEG_MAG : m;
        return ~mag + COEF_WIDTH'(1);
    endfunction

endpackage

`default_nettype wire

/* sv/variable_coefficient_stencil_generator.sv */
// The first entry of a point is offered once the point has passed stage 1 and
// stage 2; later points move up meanwhile. Interior points give 5 entries; the
// output entry sequencer sets the rate, one entry per cycle while not stalled.
// Reset (synchronous, active low) empties the pipeline and loads grid 3x3,
// conductivity 1.0, both ratios 1.0, Dirichlet mode.
// Top level of the stencil row generator; uses vcsg_pkg.
`default_nettype none

module variable_coefficient_stencil_generator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire vcsg_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output vcsg_pkg::t_out_item                 o_out_item,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vcsg_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW = vcsg_pkg::COORD_WIDTH;
    localparam int SW = CW + 1;
    localparam int GW = (SW > 13) ? SW : 13;
    localparam int KW = vcsg_pkg::COEF_WIDTH;
    localparam int XW = vcsg_pkg::WIDE_WIDTH;
    localparam int NS = vcsg_pkg::NUM_SLOTS;
    localparam logic [GW-1:0] SIZE_LIM = GW'(1) << CW;

    // configuration
    logic [12:0] r_grid_width, r_grid_height;
    logic [31:0] r_center_cond, r_ratio_x_y, r_ratio_y_x;
    logic        r_bound_mode;

    logic                           cfg_wr;
    logic [vcsg_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[vcsg_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 13'd3;
            r_grid_height <= 13'd3;
            r_center_cond <= vcsg_pkg::ONE_Q16;
            r_ratio_x_y   <= vcsg_pkg::ONE_Q16;
            r_ratio_y_x   <= vcsg_pkg::ONE_Q16;
            r_bound_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                vcsg_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[12:0];
                vcsg_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[12:0];
                vcsg_pkg::REG_CENTER_COND: r_center_cond <= pwdata;
                vcsg_pkg::REG_RATIO_X_Y:   r_ratio_x_y   <= pwdata;
                vcsg_pkg::REG_RATIO_Y_X:   r_ratio_y_x   <= pwdata;
                vcsg_pkg::REG_BOUND_MODE:  r_bound_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            vcsg_pkg::REG_GRID_WIDTH:  prdata = 32'(r_grid_width);
            vcsg_pkg::REG_GRID_HEIGHT: prdata = 32'(r_grid_height);
            vcsg_pkg::REG_CENTER_COND: prdata = r_center_cond;
            vcsg_pkg::REG_RATIO_X_Y:   prdata = r_ratio_x_y;
            vcsg_pkg::REG_RATIO_Y_X:   prdata = r_ratio_y_x;
            vcsg_pkg::REG_BOUND_MODE:  prdata = 32'(r_bound_mode);
            default:                   prdata = '0;
        endcase
    end

    // pipeline registers
    logic          r_s1_v;
    logic [CW-1:0] r_s1_c, r_s1_r;

    logic          r_s2_v;
    logic [CW-1:0] r_s2_c, r_s2_r;
    logic [KW-1:0] r_s2_px, r_s2_py;
    logic          r_s2_oog, r_s2_bnd;
    logic          r_s2_nb_s, r_s2_nb_w, r_s2_nb_e, r_s2_nb_n;

    logic          r_e_v;
    logic [CW-1:0] r_e_c, r_e_r;
    logic [KW-1:0] r_e_npx, r_e_npy, r_e_diag, r_e_fin;
    logic [NS-1:0] r_e_mask, r_e_sel;
    logic          r_e_oog;

    // handshake chain
    logic out_take, e_last, e_free, s2_free, s2_go, s1_free, s1_go, in_take;
    logic [NS-1:0] e_above, e_next;

    assign e_above  = r_e_mask & ~(r_e_sel | (r_e_sel - NS'(1)));
    assign e_next   = e_above & (~e_above + NS'(1));
    assign e_last   = (e_above == '0);
    assign out_take = r_e_v && !i_out_stall;
    assign e_free   = !r_e_v || (out_take && e_last);
    assign s2_free  = !r_s2_v || e_free;
    assign s2_go    = r_s2_v && e_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign s1_go    = r_s1_v && s2_free;
    assign in_take  = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // stage 1: classify the point and form the scaled conductivities
    logic [GW-1:0]   gw_ext, gh_ext;
    logic [SW-1:0]   w, h, wm1, hm1;
    logic [CW+1:0]   c3, r3, w1, w2, h1, h2;
    logic            s1_oog, s1_center, s1_bnd;
    logic [31:0]     rho;
    logic [63:0]     prod_x, prod_y;

    always_comb begin
        gw_ext = GW'(r_grid_width);
        gh_ext = GW'(r_grid_height);
        w   = (gw_ext > SIZE_LIM) ? SW'(SIZE_LIM) : SW'(gw_ext);
        h   = (gh_ext > SIZE_LIM) ? SW'(SIZE_LIM) : SW'(gh_ext);
        wm1 = w - SW'(1);
        hm1 = h - SW'(1);
        c3  = (CW+2)'(r_s1_c) + ((CW+2)'(r_s1_c) << 1);
        r3  = (CW+2)'(r_s1_r) + ((CW+2)'(r_s1_r) << 1);
        w1  = (CW+2)'(w);
        h1  = (CW+2)'(h);
        w2  = w1 << 1;
        h2  = h1 << 1;
        s1_oog    = (SW'(r_s1_c) >= w) || (SW'(r_s1_r) >= h);
        s1_center = (c3 > w1) && (c3 < w2) && (r3 > h1) && (r3 < h2);
        s1_bnd    = (r_s1_c == '0) || (r_s1_r == '0) ||
                    (SW'(r_s1_c) == wm1) || (SW'(r_s1_r) == hm1);
        rho    = s1_center ? r_center_cond : vcsg_pkg::ONE_Q16;
        prod_x = 64'(rho) * 64'(r_ratio_y_x);
        prod_y = 64'(rho) * 64'(r_ratio_x_y);
    end

    // stage 2: coefficients and the set of entries to emit
    logic [XW-1:0] sum_xy, sum_nx, sum_ny;
    logic [KW-1:0] s2_diag, s2_fin;
    logic [NS-1:0] s2_mask, s2_first;

    always_comb begin
        sum_xy = XW'(r_s2_px) + XW'(r_s2_py);
        s2_diag = vcsg_pkg::sat_pos(sum_xy << 1);
        sum_nx = (r_s2_nb_w ? XW'(r_s2_px) : '0) + (r_s2_nb_e ? XW'(r_s2_px) : '0);
        sum_ny = (r_s2_nb_s ? XW'(r_s2_py) : '0) + (r_s2_nb_n ? XW'(r_s2_py) : '0);
        s2_mask = '0;
        priority if (r_s2_oog) begin
            s2_fin = '0;
            s2_mask[vcsg_pkg::SLOT_F] = 1'b1;
        end else if (r_s2_bnd && !r_bound_mode) begin
            s2_fin = s2_diag;
            s2_mask[vcsg_pkg::SLOT_F] = 1'b1;
        end else if (r_s2_bnd) begin
            // neighbours that exist, then the count-weighted diagonal
            s2_fin = vcsg_pkg::sat_pos(sum_nx + sum_ny);
            s2_mask[vcsg_pkg::SLOT_S] = r_s2_nb_s;
            s2_mask[vcsg_pkg::SLOT_W] = r_s2_nb_w;
            s2_mask[vcsg_pkg::SLOT_E] = r_s2_nb_e;
            s2_mask[vcsg_pkg::SLOT_N] = r_s2_nb_n;
            s2_mask[vcsg_pkg::SLOT_F] = 1'b1;
        end else begin
            s2_fin = s2_diag;
            s2_mask[vcsg_pkg::SLOT_S] = 1'b1;
            s2_mask[vcsg_pkg::SLOT_W] = 1'b1;
            s2_mask[vcsg_pkg::SLOT_C] = 1'b1;
            s2_mask[vcsg_pkg::SLOT_E] = 1'b1;
            s2_mask[vcsg_pkg::SLOT_N] = 1'b1;
        end
        s2_first = s2_mask & (~s2_mask + NS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_e_v  <= 1'b0;
        end else begin
            if (s1_free) r_s1_v <= i_in_valid;
            if (s2_free) r_s2_v <= r_s1_v;
            if (e_free)  r_e_v  <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_c <= i_in_item.point_col;
            r_s1_r <= i_in_item.point_row;
        end
        if (s1_go) begin
            r_s2_c    <= r_s1_c;
            r_s2_r    <= r_s1_r;
            r_s2_px   <= KW'((prod_x + 64'd32768) >> 16);
            r_s2_py   <= KW'((prod_y + 64'd32768) >> 16);
            r_s2_oog  <= s1_oog;
            r_s2_bnd  <= s1_bnd;
            r_s2_nb_s <= (r_s1_r != '0);
            r_s2_nb_w <= (r_s1_c != '0);
            r_s2_nb_e <= (SW'(r_s1_c) != wm1);
            r_s2_nb_n <= (SW'(r_s1_r) != hm1);
        end
        if (s2_go) begin
            r_e_c    <= r_s2_c;
            r_e_r    <= r_s2_r;
            r_e_npx  <= vcsg_pkg::sat_neg(r_s2_px);
            r_e_npy  <= vcsg_pkg::sat_neg(r_s2_py);
            r_e_diag <= s2_diag;
            r_e_fin  <= s2_fin;
            r_e_mask <= s2_mask;
            r_e_sel  <= s2_first;
            r_e_oog  <= r_s2_oog;
        end else if (out_take) begin
            r_e_sel <= e_next;
        end
    end

    // entry presented by the sequencer
    always_comb begin
        o_out_item.entry_col   = r_e_c;
        o_out_item.entry_row   = r_e_r;
        o_out_item.last_entry  = e_last;
        o_out_item.out_of_grid = r_e_oog;
        priority if (r_e_sel[vcsg_pkg::SLOT_S]) begin
            o_out_item.entry_row   = r_e_r - CW'(1);
            o_out_item.coefficient = r_e_npy;
        end else if (r_e_sel[vcsg_pkg::SLOT_W]) begin
            o_out_item.entry_col   = r_e_c - CW'(1);
            o_out_item.coefficient = r_e_npx;
        end else if (r_e_sel[vcsg_pkg::SLOT_C]) begin
            o_out_item.coefficient = r_e_diag;
        end else if (r_e_sel[vcsg_pkg::SLOT_E]) begin
            o_out_item.entry_col   = r_e_c + CW'(1);
            o_out_item.coefficient = r_e_npx;
        end else if (r_e_sel[vcsg_pkg::SLOT_N]) begin
            o_out_item.entry_row   = r_e_r + CW'(1);
            o_out_item.coefficient = r_e_npy;
        end else begin
            o_out_item.coefficient = r_e_fin;
        end
    end

    assign o_out_valid = r_e_v;

`ifndef SYNTHESIS
    a_oog_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_of_grid |->
            o_out_item.last_entry && (o_out_item.coefficient == '0))
        else $error("out-of-grid item is not a single zero entry");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_v && r_s2_v && r_e_v)
        else $error("input stalled with room in the pipeline");

    a_sel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> $onehot(r_e_sel) && ((r_e_sel & r_e_mask) != '0))
        else $error("entry select outside the point's entry set");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last_entry && !i_out_stall |=> o_out_valid)
        else $error("point ended without a last entry");
`endif

endmodule

`default_nettype wire

/* dv/tb_variable_coefficient_stencil_generator.sv */
// Self-checking bench for the five-point stencil row generator: random and directed grid
// points under several register settings, every entry checked against a local row predictor.
// Depends on vcsg_pkg and variable_coefficient_stencil_generator.
`default_nettype none

module tb_variable_coefficient_stencil_generator;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int POINTS_PER_PHASE = 67;
    localparam int CWD = vcsg_pkg::COORD_WIDTH;
    localparam int KWD = vcsg_pkg::COEF_WIDTH;
    localparam logic [vcsg_pkg::REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [vcsg_pkg::REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [12:0] MAX_GRID = 13'd4096;
    localparam logic [63:0] COEF_TOP = 64'd1 << (KWD - 1);
    localparam logic [63:0] COEF_POS_LIMIT = COEF_TOP - 64'd1;
    localparam logic [63:0] COEF_MASK = (64'd1 << KWD) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    vcsg_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    vcsg_pkg::t_out_item out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [vcsg_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // register shadow
    logic [12:0] cfg_width = 13'd3;
    logic [12:0] cfg_height = 13'd3;
    logic [31:0] cfg_rho = vcsg_pkg::ONE_Q16;
    logic [31:0] cfg_rxy = vcsg_pkg::ONE_Q16;
    logic [31:0] cfg_ryx = vcsg_pkg::ONE_Q16;
    logic cfg_neumann = 1'b0;

    vcsg_pkg::t_in_item pending_points[$];
    vcsg_pkg::t_out_item expected_entries[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int points_sent = 0;
    int entries_checked = 0;
    int settings_count = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    variable_coefficient_stencil_generator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [12:0] eff_size(input logic [12:0] v);
        return (v > MAX_GRID) ? MAX_GRID : v;
    endfunction

    function automatic logic [63:0] clip_pos(input logic [63:0] m);
        return (m > COEF_POS_LIMIT) ? COEF_POS_LIMIT : m;
    endfunction

    function automatic logic [63:0] clip_neg(input logic [63:0] m);
        logic [63:0] mag;
        mag = (m > COEF_TOP) ? COEF_TOP : m;
        return (64'd0 - mag) & COEF_MASK;
    endfunction

    function automatic void push_entry(input logic [63:0] c, input logic [63:0] r,
                                       input logic [63:0] coef, input logic last,
                                       input logic oog);
        vcsg_pkg::t_out_item e;
        e.entry_col   = c[CWD-1:0];
        e.entry_row   = r[CWD-1:0];
        e.coefficient = coef[KWD-1:0];
        e.last_entry  = last;
        e.out_of_grid = oog;
        expected_entries.push_back(e);
    endfunction

    // matrix row of one grid point under the current register shadow
    function automatic void predict_row(input vcsg_pkg::t_in_item pt);
        logic [63:0] c, r, w, h, rho, px, py, nx, ny;
        c = 64'(pt.point_col);
        r = 64'(pt.point_row);
        w = 64'(eff_size(cfg_width));
        h = 64'(eff_size(cfg_height));
        nx = 64'd0;
        ny = 64'd0;
        if (c >= w || r >= h) begin
            push_entry(c, r, 64'd0, 1'b1, 1'b1);
            return;
        end
        if (64'd3 * c > w && 64'd3 * c < 64'd2 * w && 64'd3 * r > h && 64'd3 * r < 64'd2 * h)
            rho = 64'(cfg_rho);
        else
            rho = 64'(vcsg_pkg::ONE_Q16);
        px = (rho * 64'(cfg_ryx) + 64'd32768) >> 16;
        py = (rho * 64'(cfg_rxy) + 64'd32768) >> 16;
        if (c == 0 || r == 0 || c == w - 64'd1 || r == h - 64'd1) begin
            if (!cfg_neumann) begin
                push_entry(c, r, clip_pos(64'd2 * (px + py)), 1'b1, 1'b0);
            end else begin
                if (r != 0) begin
                    push_entry(c, r - 64'd1, clip_neg(py), 1'b0, 1'b0);
                    ny++;
                end
                if (c != 0) begin
                    push_entry(c - 64'd1, r, clip_neg(px), 1'b0, 1'b0);
                    nx++;
                end
                if (c != w - 64'd1) begin
                    push_entry(c + 64'd1, r, clip_neg(px), 1'b0, 1'b0);
                    nx++;
                end
                if (r != h - 64'd1) begin
                    push_entry(c, r + 64'd1, clip_neg(py), 1'b0, 1'b0);
                    ny++;
                end
                push_entry(c, r, clip_pos(nx * px + ny * py), 1'b1, 1'b0);
            end
            return;
        end
        push_entry(c, r - 64'd1, clip_neg(py), 1'b0, 1'b0);
        push_entry(c - 64'd1, r, clip_neg(px), 1'b0, 1'b0);
        push_entry(c, r, clip_pos(64'd2 * (px + py)), 1'b0, 1'b0);
        push_entry(c + 64'd1, r, clip_neg(px), 1'b0, 1'b0);
        push_entry(c, r + 64'd1, clip_neg(py), 1'b1, 1'b0);
    endfunction

    function automatic void check_entry(input vcsg_pkg::t_out_item got);
        vcsg_pkg::t_out_item want;
        if (expected_entries.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected entry: col %0d row %0d coef %0d last %0b oog %0b",
                         got.entry_col, got.entry_row, got.coefficient,
                         got.last_entry, got.out_of_grid);
            fail_count++;
            return;
        end
        want = expected_entries.pop_front();
        entries_checked++;
        if (got.entry_col !== want.entry_col || got.entry_row !== want.entry_row ||
            got.coefficient !== want.coefficient || got.last_entry !== want.last_entry ||
            got.out_of_grid !== want.out_of_grid) begin
            if (fail_count < 10) begin
                $display("entry mismatch: want col %0d row %0d coef %0d last %0b oog %0b",
                         want.entry_col, want.entry_row, want.coefficient,
                         want.last_entry, want.out_of_grid);
                $display("                 got col %0d row %0d coef %0d last %0b oog %0b",
                         got.entry_col, got.entry_row, got.coefficient,
                         got.last_entry, got.out_of_grid);
            end
            fail_count++;
        end
    endfunction

    // driver: points leave the pending queue, a stalled item stays put
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_row(in_item);
                points_sent++;
            end
            if (!(in_valid && in_stall)) begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_points.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and random back-pressure
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            check_entry(out_item);
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_variable_coefficient_stencil_generator: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [vcsg_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vcsg_pkg::REG_GRID_WIDTH:  cfg_width = data[12:0];
            vcsg_pkg::REG_GRID_HEIGHT: cfg_height = data[12:0];
            vcsg_pkg::REG_CENTER_COND: cfg_rho = data;
            vcsg_pkg::REG_RATIO_X_Y:   cfg_rxy = data;
            vcsg_pkg::REG_RATIO_Y_X:   cfg_ryx = data;
            vcsg_pkg::REG_BOUND_MODE:  cfg_neumann = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic set_all(input logic [12:0] w, input logic [12:0] h, input logic [31:0] rho,
                           input logic [31:0] rxy, input logic [31:0] ryx, input logic mode);
        write_reg(vcsg_pkg::REG_GRID_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
        write_reg(vcsg_pkg::REG_GRID_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'(h));
        write_reg(vcsg_pkg::REG_CENTER_COND, rho);
        write_reg(vcsg_pkg::REG_RATIO_X_Y, rxy);
        write_reg(vcsg_pkg::REG_RATIO_Y_X, ryx);
        write_reg(vcsg_pkg::REG_BOUND_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(mode));
        settings_count++;
        @(negedge clk);
    endtask

    // wait until every point has gone in and every entry has come out
    task automatic drain();
        @(negedge clk);
        while (pending_points.size() != 0 || in_valid || expected_entries.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic add_point(input int c, input int r);
        vcsg_pkg::t_in_item p;
        p.point_col = CWD'(c);
        p.point_row = CWD'(r);
        pending_points.push_back(p);
    endtask

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd2;
            3: return MAX_GRID;
            4: return 13'h1FFF;
            5, 6: return 13'($urandom_range(2, 4096));
            default: return 13'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return vcsg_pkg::ONE_Q16;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // edges and the central region come up more often than a flat draw gives
    function automatic logic [CWD-1:0] pick_coord(input logic [12:0] n);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CWD'(n - 13'd1);
            2: return CWD'(n / 2);
            default: return CWD'($urandom_range(0, n - 1));
        endcase
    endfunction

    task automatic random_phase(input int n_points);
        logic [12:0] w, h;
        vcsg_pkg::t_in_item p;
        set_all(pick_size(), pick_size(), pick_q16(), pick_q16(), pick_q16(),
                1'($urandom_range(0, 1)));
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        for (int k = 0; k < n_points; k++) begin
            p.point_col = CWD'($urandom);
            p.point_row = CWD'($urandom);
            if ($urandom_range(0, 7) != 0 && w != 0 && h != 0) begin
                p.point_col = pick_coord(w);
                p.point_row = pick_coord(h);
            end
            pending_points.push_back(p);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct  = 19;
        recv_stall_pct = 66;
        @(negedge clk);

        // reset settings: 3x3 Dirichlet, the middle point is the only interior one
        add_point(1, 1);
        add_point(0, 0);
        add_point(2, 1);
        add_point(3, 1);
        add_point(1, 3);
        add_point(4095, 4095);
        add_point(0, 2);
        drain();

        // Neumann on 5x4 with uneven ratios: corners, edges, centre region, other interior, off-grid points
        set_all(13'd5, 13'd4, 32'h0002_8000, 32'h0001_8000, 32'h0000_8000, 1'b1);
        add_point(0, 0);
        add_point(4, 3);
        add_point(0, 3);
        add_point(4, 0);
        add_point(2, 0);
        add_point(0, 2);
        add_point(2, 2);
        add_point(1, 1);
        add_point(5, 0);
        add_point(0, 4);
        drain();

        // oversized width clamps, full-scale values saturate both signs
        set_all(13'h1FFF, MAX_GRID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_point(2048, 2048);
        add_point(0, 0);
        add_point(4095, 4095);
        add_point(4095, 0);
        drain();

        // single column, zero coefficients, spare addresses must be ignored
        set_all(13'd1, 13'd2, 32'd0, 32'd0, 32'd0, 1'b1);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        @(negedge clk);
        add_point(0, 0);
        add_point(0, 1);
        add_point(1, 0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 2) begin
                send_idle_pct  = 66;
                recv_stall_pct = 19;
            end else if (ph == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            random_phase(POINTS_PER_PHASE);
        end

        repeat (10) @(negedge clk);
        if (expected_entries.size() != 0) begin
            $display("%0d expected entries never arrived", expected_entries.size());
            fail_count++;
        end
        $display("stencil run: %0d points sent, %0d entries checked, %0d register settings",
                 points_sent, entries_checked, settings_count);
        $display("failures: %0d", fail_count);
        if (fail_count == 0)
            $display("tb_variable_coefficient_stencil_generator: done, clean");
        else
            $display("tb_variable_coefficient_stencil_generator: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
